### rtl/core/lkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and codes for the fully associative LRU key cache.
// ----------------------------------------------------------------------------
package lkc_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int OP_W    = 3;
    localparam int CNT_W   = 5;
    localparam int LIMIT_W = 5;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_PROBE      = 3'd2,
        OP_INVALIDATE = 3'd3,
        OP_CLEAR      = 3'd4
    } t_lkc_op;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_lkc_state;

    // Input transfer
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_lkc_in;

    // Output transfer
    typedef struct packed {
        logic             hit;
        logic [PAY_W-1:0] payload_out;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [CNT_W-1:0] entry_count;
    } t_lkc_out;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic             match_en;
        logic             update_en;
        logic             do_evict;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             hit;
        logic             any_free;
    } t_lkc_cmd;

    // Data passed from one cell to the next
    typedef struct packed {
        logic             hit;
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] ev_key;
        logic             taken;
    } t_lkc_link;

endpackage

### rtl/core/lru_keyed_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_cache_top
// Fully associative key to payload cache with least-recently-used
// replacement, built as a row of entry cells.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one operation per
//    transfer: lookup, insert, probe, invalidate key or invalidate all.
//  - Output channel (o_out_valid / i_out_ready) returns one result per
//    operation, in order, from an output register.
//  - i_cfg_we / i_cfg_wdata write the entry limit (zero = full capacity);
//    write it only while no operation is in flight.
//  - Each operation passes through a compare state (associative compare and LRU
//    eviction) and an update state (rank update), and its result is written
//    to the output register at the end of the update state. A new operation
//    is taken in the update state while the result can move on, so a new
//    operation overlaps the update of the last one but not its compare.
//  - While a result waits on i_out_ready, one further operation may be
//    taken and evaluated; it holds in its update cycle until the output
//    register frees up.
//  - Reset empties the cache and sets the limit to zero (full capacity).
// ----------------------------------------------------------------------------
module lru_keyed_cache_top
    import lkc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_lkc_in            i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_lkc_out           o_out,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_lkc_state       r_state, n_state;
    logic [LIMIT_W-1:0] r_max_entries;
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic [CW-1:0]    r_count, n_count;
    logic             r_evicted;
    logic [KEY_W-1:0] r_ev_key;
    logic             r_out_valid;
    t_lkc_out         r_out;

    logic             w_accept;
    logic             w_can_finish;
    logic             w_match_en;
    logic             w_update_en;
    logic [LW-1:0]    w_limit;
    logic [LW-1:0]    w_count_ext;
    logic             w_do_evict;
    t_lkc_cmd         w_cmd;
    t_lkc_link        w_link [0:ENTRIES];
    logic [RW-1:0]    w_rank [0:ENTRIES];
    logic [RW-1:0]    w_lru_rank;
    t_lkc_out         w_res;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_can_finish = !r_out_valid || i_out_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= '0;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MATCH;
            S_MATCH:  n_state = S_UPDATE;
            S_UPDATE: begin
                if (w_can_finish) begin
                    n_state = w_accept ? S_MATCH : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_match_en  = 1'b0;
        w_update_en = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_MATCH:  w_match_en = 1'b1;
            S_UPDATE: begin
                o_in_ready  = w_can_finish;
                w_update_en = w_can_finish;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operation register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_in.op;
            r_key     <= i_in.key;
            r_payload <= i_in.payload;
        end
    end

    // Effective limit and eviction decision
    always_comb begin
        w_limit = LW'(r_max_entries);
        if (r_max_entries == '0 || LW'(r_max_entries) > LW'(ENTRIES)) begin
            w_limit = LW'(ENTRIES);
        end
    end

    assign w_do_evict = (r_op == OP_INSERT) && (LW'(r_count) >= w_limit);
    assign w_lru_rank = RW'(r_count - CW'(1));

    // Broadcast to the cells
    always_comb begin
        w_cmd.match_en  = w_match_en;
        w_cmd.update_en = w_update_en;
        w_cmd.do_evict  = w_do_evict;
        w_cmd.op        = r_op;
        w_cmd.key       = r_key;
        w_cmd.payload   = r_payload;
        w_cmd.hit       = w_link[ENTRIES].hit;
        w_cmd.any_free  = w_link[ENTRIES].taken;
    end

    // Row of entry cells
    assign w_link[0] = '0;
    assign w_rank[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkc_cell #(
            .RW(RW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_lru_rank (w_lru_rank),
            .i_hit_rank (w_rank[ENTRIES]),
            .i_link     (w_link[g]),
            .i_rank_or  (w_rank[g]),
            .o_link     (w_link[g+1]),
            .o_rank_or  (w_rank[g+1])
        );
    end

    // Entry count after the update
    always_comb begin
        n_count = r_count;
        case (r_op)
            OP_INSERT: begin
                if (!w_link[ENTRIES].hit && w_link[ENTRIES].taken) begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_INVALIDATE: begin
                if (w_link[ENTRIES].hit) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_CLEAR: n_count = '0;
            default: begin
            end
        endcase
    end

    // Entry count and eviction capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_match_en && w_do_evict) begin
            r_count <= r_count - CW'(1);
        end else if (w_update_en) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match_en) begin
            r_evicted <= w_do_evict;
            r_ev_key  <= w_link[ENTRIES].ev_key;
        end
    end

    // Result assembly
    assign w_count_ext = LW'(n_count);

    always_comb begin
        w_res             = '0;
        w_res.evicted     = r_evicted;
        w_res.evicted_key = r_ev_key;
        w_res.entry_count = w_count_ext[CNT_W-1:0];
        case (r_op) inside
            OP_LOOKUP: begin
                w_res.hit         = w_link[ENTRIES].hit;
                w_res.payload_out = w_link[ENTRIES].payload;
            end
            OP_PROBE, OP_INVALIDATE: w_res.hit = w_link[ENTRIES].hit;
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update_en) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/lkc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_cell
// One cache entry: valid, key, payload and recency rank, with its local
// match, eviction and rank update logic. Reduced results ripple along the
// row through the link ports.
// ----------------------------------------------------------------------------
module lkc_cell
    import lkc_pkg::*;
#(
    parameter int RW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_lkc_cmd      i_cmd,
    input  logic [RW-1:0] i_lru_rank,
    input  logic [RW-1:0] i_hit_rank,
    input  t_lkc_link     i_link,
    input  logic [RW-1:0] i_rank_or,
    output t_lkc_link     o_link,
    output logic [RW-1:0] o_rank_or
);

    logic             r_valid;
    logic             r_match;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic [RW-1:0]    r_rank;

    logic w_match;
    logic w_lru;
    logic w_sel_free;

    // Local compares during the match phase
    assign w_match    = r_valid && (r_key == i_cmd.key);
    assign w_lru      = r_valid && i_cmd.do_evict && (r_rank == i_lru_rank);
    // First free slot along the row
    assign w_sel_free = !r_valid && !i_link.taken;

    // Pass reduced values on to the next cell
    always_comb begin
        o_link.hit     = i_link.hit | r_match;
        o_link.payload = i_link.payload | (r_match ? r_payload : '0);
        o_link.ev_key  = i_link.ev_key | (w_lru ? r_key : '0);
        o_link.taken   = i_link.taken | !r_valid;
        o_rank_or      = i_rank_or | (r_match ? r_rank : '0);
    end

    // Control state: valid and match flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else if (i_cmd.match_en) begin
            r_match <= w_match && !w_lru;
            if (w_lru) begin
                r_valid <= 1'b0;
            end
        end else if (i_cmd.update_en) begin
            case (i_cmd.op)
                OP_INSERT: begin
                    if (!i_cmd.hit && i_cmd.any_free && w_sel_free) begin
                        r_valid <= 1'b1;
                    end
                end
                OP_INVALIDATE: begin
                    if (i_cmd.hit && r_match) begin
                        r_valid <= 1'b0;
                    end
                end
                OP_CLEAR: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Entry contents and rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.update_en) begin
            case (i_cmd.op) inside
                OP_LOOKUP, OP_INSERT: begin
                    if (i_cmd.hit) begin
                        if (r_match) begin
                            r_rank <= '0;
                            if (i_cmd.op == OP_INSERT) begin
                                r_payload <= i_cmd.payload;
                            end
                        end else if (r_valid && r_rank < i_hit_rank) begin
                            r_rank <= r_rank + RW'(1);
                        end
                    end else if (i_cmd.op == OP_INSERT && i_cmd.any_free) begin
                        if (r_valid) begin
                            r_rank <= r_rank + RW'(1);
                        end else if (w_sel_free) begin
                            r_key     <= i_cmd.key;
                            r_payload <= i_cmd.payload;
                            r_rank    <= '0;
                        end
                    end
                end
                OP_INVALIDATE: begin
                    if (i_cmd.hit && !r_match && r_valid && r_rank > i_hit_rank) begin
                        r_rank <= r_rank - RW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/lkc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_checker
// Port-level checks for the LRU key cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkc_checker
    import lkc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_lkc_in            i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_lkc_out           o_out,
    input logic               i_cfg_we,
    input logic [LIMIT_W-1:0] i_cfg_wdata
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && o_in_ready;

    // Compare cycle follows every input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("input taken during compare cycle");

    // A freshly raised result traces back to an input transfer through the compare and update states
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_xfer, 3))
        else $error("result without matching input transfer");

    // Payload only on a hit
    a_payload_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.payload_out != '0) |-> o_out.hit)
        else $error("payload returned without hit");

    // Eviction reports come only from inserts, which never hit
    a_evict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.evicted || o_out.evicted_key != '0))
            |-> (o_out.evicted && !o_out.hit))
        else $error("inconsistent eviction report");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

endmodule

bind lru_keyed_cache_top lkc_checker u_lkc_checker (.*);

### dv/tb_lru_keyed_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_keyed_cache_top
// Self-checking testbench for the fully associative LRU key cache.
//
// A clocked driver pops operations from a queue and offers them on the input
// channel. Every accepted transfer is run through a local cache predictor,
// and the expected result is queued. A clocked monitor takes the results
// and compares them field by field, in order. A short directed sequence
// covers the edge cases. Random batches then run over a small key pool
// under several entry limits and idle patterns, with two long output stalls.
// ----------------------------------------------------------------------------
module tb_lru_keyed_cache_top;
    import lkc_pkg::*;

    localparam int ENTRIES = 16;
    // Opcodes the block does not define; they must leave the state alone
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int LONG_HOLD = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    t_lkc_in            in_item = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    t_lkc_out           o_out;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    lru_keyed_cache_top #(.ENTRIES(ENTRIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Traffic shaping, set by the sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    t_lkc_in  ops_to_send[$];
    t_lkc_out expected_results[$];

    // Predicted cache contents
    logic               slot_valid [ENTRIES];
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [PAY_W-1:0]   slot_pay   [ENTRIES];
    int unsigned        slot_age   [ENTRIES];
    logic [LIMIT_W-1:0] entry_limit = '0;

    // Run statistics
    int ops_seen [8];
    int hit_total = 0;
    int evict_total = 0;
    int results_checked = 0;
    int mismatches = 0;
    int limit_writes = 0;
    logic hold_long = 1'b0;

    initial begin
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_pay[i]   = '0;
            slot_age[i]   = 0;
        end
        foreach (ops_seen[i]) ops_seen[i] = 0;
    end

    // ------------------------------------------------------------------------
    // Cache predictor
    // ------------------------------------------------------------------------
    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    function automatic int unsigned occupancy();
        int unsigned n;
        n = 0;
        foreach (slot_valid[i]) if (slot_valid[i]) n++;
        return n;
    endfunction

    // Move an entry to the front; younger entries age by one
    function automatic void promote(input int idx);
        int unsigned r;
        r = slot_age[idx];
        foreach (slot_valid[i])
            if (slot_valid[i] && i != idx && slot_age[i] < r) slot_age[i]++;
        slot_age[idx] = 0;
    endfunction

    // Remove an entry and close the gap in the ages
    function automatic void drop(input int idx);
        int unsigned r;
        r = slot_age[idx];
        slot_valid[idx] = 1'b0;
        foreach (slot_valid[i])
            if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
    endfunction

    function automatic t_lkc_out cache_apply(input t_lkc_in item);
        t_lkc_out    res;
        int          idx;
        int          oldest;
        int unsigned cap;
        res = '0;
        idx = -1;
        case (item.op)
            OP_LOOKUP: begin
                idx = find_slot(item.key);
                if (idx >= 0) begin
                    res.hit         = 1'b1;
                    res.payload_out = slot_pay[idx];
                    promote(idx);
                end
            end
            OP_INSERT: begin
                cap = (entry_limit == 0 || entry_limit > ENTRIES) ? ENTRIES : entry_limit;
                // evict first, even when the key is already cached
                if (occupancy() >= cap) begin
                    oldest = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_valid[i]) begin
                            if (oldest < 0) oldest = i;
                            else if (slot_age[i] > slot_age[oldest]) oldest = i;
                        end
                    end
                    if (oldest >= 0) begin
                        res.evicted     = 1'b1;
                        res.evicted_key = slot_key[oldest];
                        drop(oldest);
                    end
                end
                idx = find_slot(item.key);
                if (idx >= 0) begin
                    slot_pay[idx] = item.payload;
                    promote(idx);
                end else begin
                    // new entry goes to the lowest free slot
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!slot_valid[i]) begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx >= 0) begin
                        foreach (slot_valid[i]) if (slot_valid[i]) slot_age[i]++;
                        slot_valid[idx] = 1'b1;
                        slot_key[idx]   = item.key;
                        slot_pay[idx]   = item.payload;
                        slot_age[idx]   = 0;
                    end
                end
            end
            OP_PROBE: begin
                res.hit = (find_slot(item.key) >= 0);
            end
            OP_INVALIDATE: begin
                idx = find_slot(item.key);
                if (idx >= 0) begin
                    res.hit = 1'b1;
                    drop(idx);
                end
            end
            OP_CLEAR: begin
                foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(occupancy());
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Input driver: offers queued operations, predicts on each transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : op_driver
        t_lkc_out want;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                want = cache_apply(in_item);
                expected_results.push_back(want);
                ops_seen[in_item.op]++;
                if (want.hit) hit_total++;
                if (want.evicted) evict_total++;
            end
            if (!in_valid || o_in_ready) begin
                if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item  <= ops_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each transfer, drives random backpressure
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_lkc_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result 0x%0h arrived with nothing outstanding", o_out);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(o_out.hit));
                    check_field("payload_out", want.payload_out, o_out.payload_out);
                    check_field("evicted", 32'(want.evicted), 32'(o_out.evicted));
                    check_field("evicted_key", want.evicted_key, o_out.evicted_key);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(o_out.entry_count));
                end
                results_checked++;
            end
            if (hold_long) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Long receiver stalls mid-batch so the block backs up into its input
    initial begin : long_stall
        wait (results_checked >= 250);
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_long <= 1'b0;
        wait (results_checked >= 850);
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    task automatic push_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] payload);
        t_lkc_in item;
        item.op      = op;
        item.key     = key;
        item.payload = payload;
        ops_to_send.push_back(item);
    endtask

    // Hold off until every queued operation has produced its result
    task automatic wait_idle();
        do @(negedge i_clk);
        while (ops_to_send.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        entry_limit = value;
        limit_writes++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_random(input int count, input int pool_size);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] key;
        logic [OP_W-1:0]  op;
        int               r;
        for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_INSERT;
            else if (r < 65) op = OP_LOOKUP;
            else if (r < 78) op = OP_PROBE;
            else if (r < 91) op = OP_INVALIDATE;
            else if (r < 92) op = OP_CLEAR;
            else if (r < 95) op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            else             op = OP_LOOKUP;
            // mostly pooled keys so hits and evictions are common
            if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, pool_size - 1)];
            else key = $urandom;
            push_op(op, key, $urandom);
        end
    endtask

    // Two batches under one limit, with a full drain between them
    task automatic random_phase(input logic [LIMIT_W-1:0] limit, input int pool_size);
        set_limit(limit);
        queue_random(100, pool_size);
        wait_idle();
        queue_random(100, pool_size);
        wait_idle();
    endtask

    initial begin
        wait (i_rst_n);
        @(negedge i_clk);
        send_idle_pct  = 25;
        recv_stall_pct = 87;

        // Directed: limit of three entries
        set_limit(5'd3);
        push_op(OP_LOOKUP, 32'h0000_0000, 32'h0);             // empty cache miss
        push_op(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(OP_LOOKUP, 32'h0000_0000, 32'h0);             // hit, now most recent
        push_op(OP_PROBE, 32'hFFFF_FFFF, 32'h0);
        push_op(OP_PROBE, 32'h0001_2345, 32'h0);              // miss
        push_op(OP_INSERT, 32'h0000_0000, 32'h5555_AAAA);     // overwrite in place
        push_op(OP_INSERT, 32'hA5A5_A5A5, 32'h1234_5678);     // fills to the limit
        push_op(OP_INSERT, 32'hFFFF_FFFF, 32'hDEAD_0001);     // evicts itself, reinserts
        push_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        push_op(OP_INVALIDATE, 32'h0000_0000, 32'h0);
        push_op(OP_INVALIDATE, 32'h0000_0000, 32'h0);         // already gone
        push_op(OP_UNUSED_FIRST, $urandom, $urandom);
        push_op(OP_UNUSED_MID, $urandom, $urandom);
        push_op(OP_UNUSED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Directed: limit lowered below the current fill
        set_limit(5'd1);
        push_op(OP_INSERT, 32'h0000_0007, 32'h7777_7777);
        push_op(OP_INSERT, 32'h0000_0008, 32'h8888_8888);
        push_op(OP_CLEAR, 32'h0, 32'h0);
        push_op(OP_LOOKUP, 32'h0000_0008, 32'h0);
        wait_idle();

        // Random: above capacity and full capacity
        random_phase(5'd31, 24);
        random_phase(5'd16, 24);

        send_idle_pct  = 87;
        recv_stall_pct = 25;
        random_phase(5'd5, 10);
        random_phase(5'd1, 4);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(5'd0, 24);
        random_phase(5'd12, 20);

        $display("Covered %0d inserts, %0d lookups, %0d probes, %0d invalidates, %0d clears,",
                 ops_seen[OP_INSERT], ops_seen[OP_LOOKUP], ops_seen[OP_PROBE],
                 ops_seen[OP_INVALIDATE], ops_seen[OP_CLEAR]);
        $display("%0d unused opcodes, %0d hits, %0d evictions over %0d limit writes; %0d checked",
                 ops_seen[OP_UNUSED_FIRST] + ops_seen[OP_UNUSED_MID]
                 + ops_seen[OP_UNUSED_LAST], hit_total, evict_total,
                 limit_writes, results_checked);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
